[rtl/tafx_pkg.sv]
package tafx_pkg;

    localparam int FFT_POINTS_DEF      = 8;
    localparam int COARSE_CHANNELS_DEF = 128;
    localparam int ACC_BITS_DEF        = 48;

    // pi/2 in Q30
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    localparam logic [1:0] MODE_SAMPLE = 2'd0;
    localparam logic [1:0] MODE_READ   = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    localparam logic [2:0] CFG_ANT_A            = 3'd0;
    localparam logic [2:0] CFG_ANT_B            = 3'd1;
    localparam logic [2:0] CFG_ZAP_DC           = 3'd2;
    localparam logic [2:0] CFG_DUAL_SIDEBAND    = 3'd3;
    localparam logic [2:0] CFG_BATCHES_PER_DUMP = 3'd4;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_ROUND,
        S_PROD,
        S_ACC
    } state_t;

    function automatic longint unsigned div_small(longint unsigned a, int unsigned n);
        case (n)
            1:       return a / 1;
            2:       return a / 2;
            3:       return a / 3;
            4:       return a / 4;
            5:       return a / 5;
            6:       return a / 6;
            7:       return a / 7;
            8:       return a / 8;
            9:       return a / 9;
            10:      return a / 10;
            11:      return a / 11;
            12:      return a / 12;
            13:      return a / 13;
            14:      return a / 14;
            15:      return a / 15;
            16:      return a / 16;
            17:      return a / 17;
            18:      return a / 18;
            19:      return a / 19;
            20:      return a / 20;
            21:      return a / 21;
            22:      return a / 22;
            23:      return a / 23;
            24:      return a / 24;
            default: return a;
        endcase
    endfunction

    function automatic logic signed [15:0] q30_to_q15(longint v);
        longint r;
        if (v < 0) begin
            v = 0;
        end
        r = (v + 16384) >>> 15;
        if (r > 32767) begin
            return 16'sd32767;
        end
        return 16'(r);
    endfunction

    // twiddle {cos, sin} in Q1.15 from a first-quadrant angle x (Q30) and quadrant q
    function automatic logic [31:0] tw_pair(longint unsigned x, int unsigned q);
        longint unsigned term;
        longint cs;
        longint sn;
        longint t;
        int unsigned nn;
        logic signed [15:0] cq;
        logic signed [15:0] sq;
        logic signed [15:0] c;
        logic signed [15:0] s;
        term = 64'd1 << 30;
        cs = longint'(term);
        sn = 0;
        for (nn = 1; nn <= 24; nn++) begin
            term = div_small((term * x) >> 30, nn);
            t = nn[1] ? -longint'(term) : longint'(term);
            if (nn[0]) begin
                sn = sn + t;
            end else begin
                cs = cs + t;
            end
        end
        cq = q30_to_q15(cs);
        sq = q30_to_q15(sn);
        case (q[1:0])
            2'd0: begin
                c = cq;
                s = sq;
            end
            2'd1: begin
                c = -sq;
                s = cq;
            end
            2'd2: begin
                c = -cq;
                s = -sq;
            end
            default: begin
                c = sq;
                s = -cq;
            end
        endcase
        return {c, s};
    endfunction

endpackage

[rtl/tafx_ram.sv]
module tafx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/two_antenna_fx_correlator.sv]
// Two-antenna FX correlator. Sample items (tuser = 0) stream in channel fastest, then point;
// the selected antenna pair is kept in a frame store RAM. When a frame is complete the
// block stops taking items and, for each coarse channel and bin, runs an FFT_POINTS-step
// complex multiply-accumulate over the frame store (one read per cycle), rounds, and adds
// conj(A)*B into a saturating accumulator RAM through a read-modify-write pass. A read
// item (tuser = 1) returns one bin through the accumulator RAM read and the output
// registers, and the next item waits until that result transfer. After reset and after
// each clear item the accumulator RAM is swept to zero, and no item is taken during the
// sweep; configuration writes are accepted at any time. The 1/127.5 scaling is left to
// software.
module two_antenna_fx_correlator #(
    parameter int FFT_POINTS      = tafx_pkg::FFT_POINTS_DEF,
    parameter int COARSE_CHANNELS = tafx_pkg::COARSE_CHANNELS_DEF,
    parameter int ACC_BITS        = tafx_pkg::ACC_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // a0_re, a0_im, a1_re, a1_im, a2_re, a2_im, a3_re, a3_im, read_index, zero pad
    input  logic [79:0]  s_tdata,
    // mode
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // cross_re, cross_im, auto_a, auto_b, frames_done, dump_done, zero pad
    output logic [215:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    localparam int FRAME_ITEMS = FFT_POINTS * COARSE_CHANNELS;
    localparam int ADDR_W      = $clog2(FRAME_ITEMS);
    localparam int T_W         = $clog2(FFT_POINTS);
    localparam int CH_W        = (COARSE_CHANNELS > 1) ? $clog2(COARSE_CHANNELS) : 1;
    localparam int SUM_W       = 25 + $clog2(FFT_POINTS);
    localparam int BIN_W       = SUM_W + 1 - 15;
    localparam int PROD_W      = 2 * BIN_W + 1;
    localparam int SAT_W       = ((ACC_BITS > PROD_W) ? ACC_BITS : PROD_W) + 2;
    localparam int HALF_SHIFT  = FFT_POINTS / 2;

    localparam logic signed [SAT_W-1:0] ACC_MAX = (SAT_W'(1) <<< (ACC_BITS - 1)) - SAT_W'(1);
    localparam logic signed [SAT_W-1:0] ACC_MIN = -ACC_MAX - SAT_W'(1);
    localparam logic [SAT_W-1:0]        TOT_MAX = (SAT_W'(1) << ACC_BITS) - SAT_W'(1);

    tafx_pkg::state_t state_reg, state_next;

    logic [1:0]  ant_a_reg, ant_b_reg;
    logic        zap_reg, dsb_reg;
    logic [15:0] bpd_reg;

    logic [ADDR_W-1:0] pos_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [15:0]       frame_cnt_reg;
    logic [ACC_BITS-1:0] tot_a_reg, tot_b_reg;

    logic [CH_W-1:0]   ch_reg, ch_next;
    logic [ADDR_W-1:0] ch_base_reg;
    logic [T_W-1:0]    k_reg;
    logic [T_W-1:0]    n_reg;
    logic [T_W-1:0]    t_reg, t_d_reg;
    logic [ADDR_W-1:0] faddr_reg;
    logic              mac_v_reg;

    logic signed [SUM_W-1:0] sum_ar_reg, sum_ai_reg, sum_br_reg, sum_bi_reg;
    logic signed [BIN_W-1:0] xr_reg, xi_reg, yr_reg, yi_reg;
    logic [ADDR_W-1:0]       idx_reg;
    logic signed [PROD_W-1:0] cr_p_reg, ci_p_reg;
    logic [PROD_W-1:0]        pa_p_reg, pb_p_reg;

    logic        rd_pend_reg, rd_oor_reg, m_valid_reg;
    logic [47:0] cr_o_reg, ci_o_reg, aa_o_reg, ab_o_reg;
    logic [15:0] fd_o_reg;
    logic        dd_o_reg;

    // twiddle table, worked out at elaboration
    logic signed [15:0] tw_c [FFT_POINTS];
    logic signed [15:0] tw_s [FFT_POINTS];

    for (genvar gk = 0; gk < FFT_POINTS; gk++) begin : g_tw
        localparam int unsigned     TQ = (4 * gk) / FFT_POINTS;
        localparam longint unsigned TR = 4 * gk - TQ * FFT_POINTS;
        localparam longint unsigned TX =
            (TR * tafx_pkg::HALF_PI_Q30 + FFT_POINTS / 2) / FFT_POINTS;
        localparam logic [31:0] TW = tafx_pkg::tw_pair(TX, TQ);
        assign tw_c[gk] = TW[31:16];
        assign tw_s[gk] = TW[15:0];
    end

    // input decode
    logic [1:0]  mode;
    logic [9:0]  read_index;
    logic [15:0] a_pair, b_pair;
    logic        dump_done;
    logic        s_acc, smp_acc, rd_acc, clr_acc, frame_end;
    logic        last_bin, last_ch;

    assign mode       = s_tuser;
    assign read_index = s_tdata[73:64];
    assign a_pair     = s_tdata[{ant_a_reg, 4'b0000} +: 16];
    assign b_pair     = s_tdata[{ant_b_reg, 4'b0000} +: 16];
    assign dump_done  = frame_cnt_reg >= bpd_reg;
    assign s_acc      = s_tvalid && s_tready;
    assign smp_acc    = s_acc && (mode == tafx_pkg::MODE_SAMPLE) && !dump_done;
    assign rd_acc     = s_acc && (mode == tafx_pkg::MODE_READ);
    assign clr_acc    = s_acc && (mode == tafx_pkg::MODE_CLEAR);
    assign frame_end  = smp_acc && (pos_reg == ADDR_W'(FRAME_ITEMS - 1));
    assign last_bin   = k_reg == T_W'(FFT_POINTS - 1);
    assign last_ch    = ch_reg == CH_W'(COARSE_CHANNELS - 1);
    assign cfg_ready  = 1'b1;

    // memories
    logic                  fs_we, fs_re;
    logic [31:0]           fs_wdata, fs_rdata;
    logic [ADDR_W-1:0]     fs_raddr;
    logic                  acc_we, acc_re;
    logic [ADDR_W-1:0]     acc_waddr, acc_raddr, idx;
    logic [2*ACC_BITS-1:0] acc_wdata, acc_rdata;
    logic [ACC_BITS-1:0]   new_re, new_im;

    tafx_ram #(.WIDTH(32), .DEPTH(FRAME_ITEMS)) u_frame_ram (
        .clk   (aclk),
        .we    (fs_we),
        .waddr (pos_reg),
        .wdata (fs_wdata),
        .re    (fs_re),
        .raddr (fs_raddr),
        .rdata (fs_rdata)
    );

    tafx_ram #(.WIDTH(2 * ACC_BITS), .DEPTH(FRAME_ITEMS)) u_acc_ram (
        .clk   (aclk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .re    (acc_re),
        .raddr (acc_raddr),
        .rdata (acc_rdata)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tafx_pkg::S_CLEAR: begin
                if (clr_cnt_reg == ADDR_W'(FRAME_ITEMS - 1)) begin
                    state_next = tafx_pkg::S_IDLE;
                end
            end
            tafx_pkg::S_IDLE: begin
                if (clr_acc) begin
                    state_next = tafx_pkg::S_CLEAR;
                end else if (frame_end) begin
                    state_next = tafx_pkg::S_MAC;
                end
            end
            tafx_pkg::S_MAC: begin
                if (n_reg == T_W'(FFT_POINTS - 1)) begin
                    state_next = tafx_pkg::S_DRAIN;
                end
            end
            tafx_pkg::S_DRAIN: state_next = tafx_pkg::S_ROUND;
            tafx_pkg::S_ROUND: state_next = tafx_pkg::S_PROD;
            tafx_pkg::S_PROD:  state_next = tafx_pkg::S_ACC;
            tafx_pkg::S_ACC: begin
                if (last_bin && last_ch) begin
                    state_next = tafx_pkg::S_IDLE;
                end else begin
                    state_next = tafx_pkg::S_MAC;
                end
            end
            default: state_next = tafx_pkg::S_CLEAR;
        endcase
    end

    // control outputs
    always_comb begin
        s_tready  = 1'b0;
        fs_re     = 1'b0;
        acc_re    = rd_acc;
        acc_raddr = ADDR_W'(read_index);
        acc_we    = 1'b0;
        acc_waddr = idx_reg;
        acc_wdata = {new_im, new_re};
        case (state_reg)
            tafx_pkg::S_CLEAR: begin
                acc_we    = 1'b1;
                acc_waddr = clr_cnt_reg;
                acc_wdata = '0;
            end
            tafx_pkg::S_IDLE: begin
                s_tready = !rd_pend_reg && !m_valid_reg;
            end
            tafx_pkg::S_MAC: begin
                fs_re = 1'b1;
            end
            tafx_pkg::S_ROUND: begin
                acc_re    = 1'b1;
                acc_raddr = idx;
            end
            tafx_pkg::S_ACC: begin
                acc_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign fs_we    = smp_acc;
    assign fs_wdata = {b_pair, a_pair};
    assign fs_raddr = faddr_reg;

    // channel / bin stepping
    logic [T_W:0] t_sum, i_sum;
    logic [T_W-1:0] t_step, bin_i;

    always_comb begin
        ch_next = ch_reg;
        if (state_reg == tafx_pkg::S_ACC && last_bin) begin
            ch_next = last_ch ? '0 : ch_reg + CH_W'(1);
        end
        t_sum  = {1'b0, t_reg} + {1'b0, k_reg};
        t_step = (t_sum >= (T_W + 1)'(FFT_POINTS)) ? T_W'(t_sum - (T_W + 1)'(FFT_POINTS))
                                                    : T_W'(t_sum);
        i_sum  = {1'b0, k_reg} + (T_W + 1)'(HALF_SHIFT);
        bin_i  = (i_sum >= (T_W + 1)'(FFT_POINTS)) ? T_W'(i_sum - (T_W + 1)'(FFT_POINTS))
                                                   : T_W'(i_sum);
        idx    = ch_base_reg + ADDR_W'(dsb_reg ? bin_i : k_reg);
    end

    // multiply-accumulate over one bin
    logic signed [7:0]  d_ar, d_ai, d_br, d_bi;
    logic signed [15:0] c_t, s_t;
    logic signed [23:0] p_arc, p_ais, p_aic, p_ars, p_brc, p_bis, p_bic, p_brs;
    logic signed [24:0] m_ar, m_ai, m_br, m_bi;

    always_comb begin
        d_ar  = fs_rdata[7:0];
        d_ai  = fs_rdata[15:8];
        d_br  = fs_rdata[23:16];
        d_bi  = fs_rdata[31:24];
        c_t   = tw_c[t_d_reg];
        s_t   = tw_s[t_d_reg];
        p_arc = 24'(d_ar) * 24'(c_t);
        p_ais = 24'(d_ai) * 24'(s_t);
        p_aic = 24'(d_ai) * 24'(c_t);
        p_ars = 24'(d_ar) * 24'(s_t);
        p_brc = 24'(d_br) * 24'(c_t);
        p_bis = 24'(d_bi) * 24'(s_t);
        p_bic = 24'(d_bi) * 24'(c_t);
        p_brs = 24'(d_br) * 24'(s_t);
        m_ar  = 25'(p_arc) + 25'(p_ais);
        m_ai  = 25'(p_aic) - 25'(p_ars);
        m_br  = 25'(p_brc) + 25'(p_bis);
        m_bi  = 25'(p_bic) - 25'(p_brs);
    end

    // rounding to integer bins
    logic signed [SUM_W:0] r_ar, r_ai, r_br, r_bi;
    logic zap_now;

    always_comb begin
        r_ar    = (SUM_W + 1)'(sum_ar_reg) + (SUM_W + 1)'(16384);
        r_ai    = (SUM_W + 1)'(sum_ai_reg) + (SUM_W + 1)'(16384);
        r_br    = (SUM_W + 1)'(sum_br_reg) + (SUM_W + 1)'(16384);
        r_bi    = (SUM_W + 1)'(sum_bi_reg) + (SUM_W + 1)'(16384);
        zap_now = zap_reg && (k_reg == '0);
    end

    // products and saturating sums
    logic signed [PROD_W-1:0] cr_t, ci_t, pa_t, pb_t;
    logic signed [ACC_BITS-1:0] acc_rd_re, acc_rd_im;
    logic signed [SAT_W-1:0]    s_re, s_im;
    logic [SAT_W-1:0]           u_a, u_b;
    logic [ACC_BITS-1:0]        tot_a_new, tot_b_new;

    always_comb begin
        cr_t      = PROD_W'(xr_reg) * PROD_W'(yr_reg) + PROD_W'(xi_reg) * PROD_W'(yi_reg);
        ci_t      = PROD_W'(xr_reg) * PROD_W'(yi_reg) - PROD_W'(xi_reg) * PROD_W'(yr_reg);
        pa_t      = PROD_W'(xr_reg) * PROD_W'(xr_reg) + PROD_W'(xi_reg) * PROD_W'(xi_reg);
        pb_t      = PROD_W'(yr_reg) * PROD_W'(yr_reg) + PROD_W'(yi_reg) * PROD_W'(yi_reg);
        acc_rd_re = acc_rdata[ACC_BITS-1:0];
        acc_rd_im = acc_rdata[2*ACC_BITS-1:ACC_BITS];
        s_re      = SAT_W'(acc_rd_re) + SAT_W'(cr_p_reg);
        s_im      = SAT_W'(acc_rd_im) + SAT_W'(ci_p_reg);
        new_re    = (s_re > ACC_MAX) ? ACC_BITS'(ACC_MAX) :
                    (s_re < ACC_MIN) ? ACC_BITS'(ACC_MIN) : ACC_BITS'(s_re);
        new_im    = (s_im > ACC_MAX) ? ACC_BITS'(ACC_MAX) :
                    (s_im < ACC_MIN) ? ACC_BITS'(ACC_MIN) : ACC_BITS'(s_im);
        u_a       = SAT_W'(tot_a_reg) + SAT_W'(pa_p_reg);
        u_b       = SAT_W'(tot_b_reg) + SAT_W'(pb_p_reg);
        tot_a_new = (u_a > TOT_MAX) ? ACC_BITS'(TOT_MAX) : ACC_BITS'(u_a);
        tot_b_new = (u_b > TOT_MAX) ? ACC_BITS'(TOT_MAX) : ACC_BITS'(u_b);
    end

    // read result widening
    logic signed [63:0] cr_wide, ci_wide;
    logic [63:0]        ta_wide, tb_wide;

    assign cr_wide = 64'(acc_rd_re);
    assign ci_wide = 64'(acc_rd_im);
    assign ta_wide = 64'(tot_a_reg);
    assign tb_wide = 64'(tot_b_reg);

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= tafx_pkg::S_CLEAR;
            ant_a_reg     <= 2'd0;
            ant_b_reg     <= 2'd1;
            zap_reg       <= 1'b0;
            dsb_reg       <= 1'b0;
            bpd_reg       <= 16'd1024;
            pos_reg       <= '0;
            clr_cnt_reg   <= '0;
            frame_cnt_reg <= '0;
            tot_a_reg     <= '0;
            tot_b_reg     <= '0;
            ch_reg        <= '0;
            ch_base_reg   <= '0;
            k_reg         <= '0;
            n_reg         <= '0;
            t_reg         <= '0;
            mac_v_reg     <= 1'b0;
            rd_pend_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    tafx_pkg::CFG_ANT_A:            ant_a_reg <= cfg_data[1:0];
                    tafx_pkg::CFG_ANT_B:            ant_b_reg <= cfg_data[1:0];
                    tafx_pkg::CFG_ZAP_DC:           zap_reg   <= cfg_data[0];
                    tafx_pkg::CFG_DUAL_SIDEBAND:    dsb_reg   <= cfg_data[0];
                    tafx_pkg::CFG_BATCHES_PER_DUMP: bpd_reg   <= cfg_data;
                    default: begin
                    end
                endcase
            end

            if (state_reg == tafx_pkg::S_CLEAR) begin
                clr_cnt_reg   <= clr_cnt_reg + ADDR_W'(1);
                pos_reg       <= '0;
                frame_cnt_reg <= '0;
                tot_a_reg     <= '0;
                tot_b_reg     <= '0;
            end else begin
                clr_cnt_reg <= '0;
                if (smp_acc) begin
                    pos_reg <= frame_end ? '0 : pos_reg + ADDR_W'(1);
                end
                if (state_reg == tafx_pkg::S_ACC) begin
                    tot_a_reg <= tot_a_new;
                    tot_b_reg <= tot_b_new;
                    if (last_bin && last_ch && frame_cnt_reg != 16'hFFFF) begin
                        frame_cnt_reg <= frame_cnt_reg + 16'd1;
                    end
                end
            end

            ch_reg <= ch_next;
            if (state_reg == tafx_pkg::S_ACC) begin
                k_reg <= last_bin ? '0 : k_reg + T_W'(1);
                if (last_bin) begin
                    ch_base_reg <= last_ch ? '0 : ch_base_reg + ADDR_W'(FFT_POINTS);
                end
            end

            if (state_reg == tafx_pkg::S_MAC) begin
                n_reg <= n_reg + T_W'(1);
                t_reg <= t_step;
            end else begin
                n_reg <= '0;
                t_reg <= '0;
            end
            mac_v_reg <= state_reg == tafx_pkg::S_MAC;

            if (rd_acc) begin
                rd_pend_reg <= 1'b1;
            end else if (rd_pend_reg) begin
                rd_pend_reg <= 1'b0;
            end
            if (rd_pend_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        t_d_reg   <= t_reg;
        faddr_reg <= (state_reg == tafx_pkg::S_MAC) ? faddr_reg + ADDR_W'(COARSE_CHANNELS)
                                                    : ADDR_W'(ch_next);
        if (mac_v_reg) begin
            sum_ar_reg <= sum_ar_reg + SUM_W'(m_ar);
            sum_ai_reg <= sum_ai_reg + SUM_W'(m_ai);
            sum_br_reg <= sum_br_reg + SUM_W'(m_br);
            sum_bi_reg <= sum_bi_reg + SUM_W'(m_bi);
        end else begin
            sum_ar_reg <= '0;
            sum_ai_reg <= '0;
            sum_br_reg <= '0;
            sum_bi_reg <= '0;
        end

        if (state_reg == tafx_pkg::S_ROUND) begin
            xr_reg  <= zap_now ? '0 : BIN_W'(r_ar >>> 15);
            xi_reg  <= zap_now ? '0 : BIN_W'(r_ai >>> 15);
            yr_reg  <= zap_now ? '0 : BIN_W'(r_br >>> 15);
            yi_reg  <= zap_now ? '0 : BIN_W'(r_bi >>> 15);
            idx_reg <= idx;
        end
        if (state_reg == tafx_pkg::S_PROD) begin
            cr_p_reg <= cr_t;
            ci_p_reg <= ci_t;
            pa_p_reg <= PROD_W'(pa_t);
            pb_p_reg <= PROD_W'(pb_t);
        end

        if (rd_acc) begin
            rd_oor_reg <= !({22'd0, read_index} < 32'(FRAME_ITEMS));
        end
        if (rd_pend_reg) begin
            cr_o_reg <= rd_oor_reg ? 48'd0 : cr_wide[47:0];
            ci_o_reg <= rd_oor_reg ? 48'd0 : ci_wide[47:0];
            aa_o_reg <= ta_wide[47:0];
            ab_o_reg <= tb_wide[47:0];
            fd_o_reg <= frame_cnt_reg;
            dd_o_reg <= dump_done;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, dd_o_reg, fd_o_reg, ab_o_reg, aa_o_reg, ci_o_reg, cr_o_reg};

`ifndef SYNTH
    a_result_from_read: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(rd_pend_reg))
        else $error("result raised without a pending read");

    a_rmw_address: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tafx_pkg::S_PROD) |-> ($past(acc_re) && $past(acc_raddr) == idx_reg))
        else $error("accumulator read address differs from write-back address");

    a_no_store_write_in_mac: assert property (@(posedge aclk) disable iff (!aresetn)
        fs_we |-> (!mac_v_reg && state_reg == tafx_pkg::S_IDLE))
        else $error("frame store written while a frame is processed");
`endif

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;

    localparam int POINTS   = tafx_pkg::FFT_POINTS_DEF;
    localparam int CHANNELS = tafx_pkg::COARSE_CHANNELS_DEF;
    localparam int BINS     = POINTS * CHANNELS;
    localparam int SETTLE   = BINS * (POINTS + 5) + 800;

    typedef struct {
        logic [47:0] cross_re;
        logic [47:0] cross_im;
        logic [47:0] auto_a;
        logic [47:0] auto_b;
        logic [15:0] frames_done;
        logic        dump_done;
    } bin_report_t;

    class spectrum_scoreboard;
        logic [31:0] pair_store [BINS];
        longint      acc_re [BINS];
        longint      acc_im [BINS];
        longint unsigned pow_a, pow_b;
        int          fill_pos;
        int          frames;
        logic [1:0]  sel_a, sel_b;
        logic        zap, dsb;
        logic [15:0] frames_per_dump;
        int          tw_c [POINTS];
        int          tw_s [POINTS];
        bin_report_t pending [$];
        int          errors;

        function new();
            longint unsigned x, term;
            longint cs, sn, t;
            int q, r, cq, sq;
            for (int k = 0; k < POINTS; k++) begin
                q = (4 * k) / POINTS;
                r = 4 * k - q * POINTS;
                x = (longint'(r) * tafx_pkg::HALF_PI_Q30 + POINTS / 2) / POINTS;
                term = 64'd1 << 30;
                cs = longint'(term);
                sn = 0;
                for (int n = 1; n <= 24; n++) begin
                    term = ((term * x) >> 30) / n;
                    t = ((n >> 1) & 1) ? -longint'(term) : longint'(term);
                    if (n & 1) sn += t;
                    else cs += t;
                end
                cq = to_q15(cs);
                sq = to_q15(sn);
                case (q & 3)
                    0: begin tw_c[k] = cq;  tw_s[k] = sq;  end
                    1: begin tw_c[k] = -sq; tw_s[k] = cq;  end
                    2: begin tw_c[k] = -cq; tw_s[k] = -sq; end
                    default: begin tw_c[k] = sq; tw_s[k] = -cq; end
                endcase
            end
            wipe();
            sel_a = 0;
            sel_b = 1;
            zap = 0;
            dsb = 0;
            frames_per_dump = 1024;
            errors = 0;
        endfunction

        function int to_q15(longint v);
            longint r;
            if (v < 0) v = 0;
            r = (v + 16384) >>> 15;
            return (r > 32767) ? 32767 : int'(r);
        endfunction

        function void wipe();
            foreach (acc_re[i]) begin
                acc_re[i] = 0;
                acc_im[i] = 0;
            end
            pow_a = 0;
            pow_b = 0;
            fill_pos = 0;
            frames = 0;
        endfunction

        function longint add_signed(longint a, longint b);
            longint mx, mn;
            mx = (longint'(1) <<< 47) - 1;
            mn = -mx - 1;
            if (a + b > mx) return mx;
            if (a + b < mn) return mn;
            return a + b;
        endfunction

        function longint unsigned add_power(longint unsigned a, longint unsigned b);
            longint unsigned mx;
            mx = (64'd1 << 48) - 1;
            return (a + b > mx) ? mx : a + b;
        endfunction

        function void set_reg(logic [2:0] idx, logic [15:0] val);
            case (idx)
                tafx_pkg::CFG_ANT_A:            sel_a = val[1:0];
                tafx_pkg::CFG_ANT_B:            sel_b = val[1:0];
                tafx_pkg::CFG_ZAP_DC:           zap = val[0];
                tafx_pkg::CFG_DUAL_SIDEBAND:    dsb = val[0];
                tafx_pkg::CFG_BATCHES_PER_DUMP: frames_per_dump = val;
                default: ;
            endcase
        endfunction

        // spectrum of one channel; lane 0 is antenna a, lane 1 antenna b
        function void channel_dft(int ch, int lane, ref longint ore[POINTS],
                                  ref longint oim[POINTS]);
            longint sr, si, xr, xi;
            logic [15:0] w;
            int t;
            for (int k = 0; k < POINTS; k++) begin
                sr = 0;
                si = 0;
                for (int n = 0; n < POINTS; n++) begin
                    w = pair_store[n * CHANNELS + ch][lane * 16 +: 16];
                    xr = longint'($signed(w[7:0]));
                    xi = longint'($signed(w[15:8]));
                    t = (n * k) % POINTS;
                    sr += xr * tw_c[t] + xi * tw_s[t];
                    si += xi * tw_c[t] - xr * tw_s[t];
                end
                ore[k] = (sr + 16384) >>> 15;
                oim[k] = (si + 16384) >>> 15;
            end
        endfunction

        function void integrate_frame();
            longint ar [POINTS];
            longint ai [POINTS];
            longint br [POINTS];
            longint bi [POINTS];
            int b, idx;
            for (int ch = 0; ch < CHANNELS; ch++) begin
                channel_dft(ch, 0, ar, ai);
                channel_dft(ch, 1, br, bi);
                if (zap) begin
                    ar[0] = 0; ai[0] = 0; br[0] = 0; bi[0] = 0;
                end
                for (int i = 0; i < POINTS; i++) begin
                    b = dsb ? (i + POINTS / 2) % POINTS : i;
                    idx = ch * POINTS + i;
                    acc_re[idx] = add_signed(acc_re[idx], ar[b] * br[b] + ai[b] * bi[b]);
                    acc_im[idx] = add_signed(acc_im[idx], ar[b] * bi[b] - ai[b] * br[b]);
                    pow_a = add_power(pow_a, ar[b] * ar[b] + ai[b] * ai[b]);
                    pow_b = add_power(pow_b, br[b] * br[b] + bi[b] * bi[b]);
                end
            end
            if (frames < 65535) frames++;
        endfunction

        function void note_input(logic [1:0] mode, logic [79:0] data);
            bin_report_t rep;
            int idx;
            case (mode)
                tafx_pkg::MODE_SAMPLE: begin
                    if (frames >= frames_per_dump) return;
                    if (fill_pos >= BINS) fill_pos = 0;
                    pair_store[fill_pos] = {data[sel_b * 16 +: 16], data[sel_a * 16 +: 16]};
                    fill_pos++;
                    if (fill_pos == BINS) begin
                        fill_pos = 0;
                        integrate_frame();
                    end
                end
                tafx_pkg::MODE_READ: begin
                    idx = data[73:64];
                    rep.cross_re = (idx < BINS) ? acc_re[idx][47:0] : '0;
                    rep.cross_im = (idx < BINS) ? acc_im[idx][47:0] : '0;
                    rep.auto_a = pow_a[47:0];
                    rep.auto_b = pow_b[47:0];
                    rep.frames_done = frames[15:0];
                    rep.dump_done = (frames >= frames_per_dump);
                    pending.push_back(rep);
                end
                tafx_pkg::MODE_CLEAR: wipe();
                default: ;
            endcase
        endfunction

        function void field(string name, logic [47:0] want, logic [47:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [215:0] d);
            bin_report_t rep;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result transfer %h", $time, d);
                errors++;
                return;
            end
            rep = pending.pop_front();
            field("cross_re", rep.cross_re, d[47:0]);
            field("cross_im", rep.cross_im, d[95:48]);
            field("auto_a", rep.auto_a, d[143:96]);
            field("auto_b", rep.auto_b, d[191:144]);
            field("frames_done", 48'(rep.frames_done), 48'(d[207:192]));
            field("dump_done", 48'(rep.dump_done), 48'(d[208]));
            field("pad", 48'd0, 48'(d[215:209]));
        endfunction
    endclass

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [79:0]  s_tdata = '0;
    logic [1:0]   s_tuser = tafx_pkg::MODE_SAMPLE;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [215:0] m_tdata;
    logic         cfg_valid = 0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [15:0]  cfg_data = '0;
    bit           no_gaps = 0;

    spectrum_scoreboard board = new();

    two_antenna_fx_correlator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        #2 aclk = 1;
        #2 aclk = 0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (no_gaps || r < 65) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(9);
        if (r == 0) return 8'h80;
        if (r == 1) return 8'h7f;
        return 8'($urandom);
    endfunction

    function automatic logic [79:0] pick_samples();
        logic [79:0] d;
        d = '0;
        for (int i = 0; i < 8; i++) d[i * 8 +: 8] = pick_byte();
        d[73:64] = 10'($urandom);
        return d;
    endfunction

    // receiver stalls
    int stall_left = 0;
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 0;
        end else begin
            m_tready <= 1;
            if (!no_gaps) stall_left <= pick_gap();
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata);
    end

    task automatic send_item(logic [1:0] mode, logic [79:0] data);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= mode;
        s_tdata <= data;
        do @(posedge aclk); while (!s_tready);
        board.note_input(mode, data);
    endtask

    task automatic read_bin(int idx);
        logic [79:0] d;
        d = pick_samples();
        d[73:64] = 10'(idx);
        send_item(tafx_pkg::MODE_READ, d);
    endtask

    task automatic drain_results();
        s_tvalid <= 0;
        @(posedge aclk);
        while (board.pending.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        board.set_reg(idx, val);
        @(posedge aclk);
    endtask

    // a completed frame leaves no result behind, so wait out its processing too
    task automatic quiesce();
        drain_results();
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic random_mix(int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 78) send_item(tafx_pkg::MODE_SAMPLE, pick_samples());
            else if (r < 95) read_bin($urandom_range(BINS - 1));
            else if (r < 98) send_item(tafx_pkg::MODE_CLEAR, pick_samples());
            else send_item(2'd3, pick_samples());
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1;

        read_bin(0);
        read_bin(BINS - 1);
        send_item(2'd3, '1);
        send_item(tafx_pkg::MODE_CLEAR, '0);
        read_bin(5);

        quiesce();
        write_reg(tafx_pkg::CFG_ANT_A, 16'd3);
        write_reg(tafx_pkg::CFG_ANT_B, 16'd0);
        write_reg(tafx_pkg::CFG_ZAP_DC, 16'd1);
        write_reg(tafx_pkg::CFG_DUAL_SIDEBAND, 16'd1);
        write_reg(tafx_pkg::CFG_BATCHES_PER_DUMP, 16'd1);

        // full-scale samples open the frame
        send_item(tafx_pkg::MODE_SAMPLE, {16'd0, {8{8'h80}}});
        send_item(tafx_pkg::MODE_SAMPLE, {16'd0, {8{8'h7f}}});
        send_item(tafx_pkg::MODE_SAMPLE, {16'd0, 64'h807f_807f_807f_807f});
        for (int i = 3; i < 600; i++) send_item(tafx_pkg::MODE_SAMPLE, pick_samples());

        // pair change partway through the frame
        quiesce();
        write_reg(tafx_pkg::CFG_ANT_A, 16'd2);
        no_gaps = 1;
        for (int i = 600; i < BINS; i++) send_item(tafx_pkg::MODE_SAMPLE, pick_samples());
        no_gaps = 0;
        // dump complete, so these are dropped
        for (int i = 0; i < 20; i++) send_item(tafx_pkg::MODE_SAMPLE, pick_samples());
        for (int i = 0; i < 40; i++) read_bin($urandom_range(BINS - 1));

        quiesce();
        write_reg(tafx_pkg::CFG_BATCHES_PER_DUMP, 16'd0);
        write_reg(tafx_pkg::CFG_ZAP_DC, 16'd0);
        write_reg(tafx_pkg::CFG_DUAL_SIDEBAND, 16'd0);
        write_reg(tafx_pkg::CFG_ANT_A, 16'd1);
        write_reg(tafx_pkg::CFG_ANT_B, 16'd3);
        send_item(tafx_pkg::MODE_CLEAR, '0);
        for (int i = 0; i < 10; i++) send_item(tafx_pkg::MODE_SAMPLE, pick_samples());
        read_bin(7);

        quiesce();
        write_reg(tafx_pkg::CFG_BATCHES_PER_DUMP, 16'hffff);
        send_item(tafx_pkg::MODE_CLEAR, '0);
        random_mix(820);

        drain_results();
        repeat (50) @(posedge aclk);
        if (board.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
